// File: rtl/core/mecanum_drive_mixer_core_macros.svh
// assertion macros shared by the mecanum mixer rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef MECANUM_DRIVE_MIXER_CORE_MACROS_SVH
`define MECANUM_DRIVE_MIXER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked only outside reset
`define MDM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mecanum mixer check failed");
// property checked on every edge, reset included
`define MDM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mecanum mixer check failed");
`else
`define MDM_ASSERT(lbl, clk, rst, prop)
`define MDM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/core/mdm_pkg.sv
// shared types and constants for the mecanum drive mixer
// no dependencies
package mdm_pkg;

   // command saturation limit and derived widths
   localparam int CMD_LIMIT = 10;
   localparam int MAG_W     = $clog2(CMD_LIMIT + 1);
   localparam int CMD_W     = MAG_W + 1;
   localparam int MIX_W     = CMD_W + 1;
   localparam int DIFF_W    = 9;
   localparam int PROD_W    = MAG_W + 1 + DIFF_W;

   // divide by the limit as multiply by a rounded-up reciprocal
   // exact for every product the mapping can produce
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + CMD_LIMIT - 1) / CMD_LIMIT;
   localparam int RECIP_W     = $clog2(RECIP + 1);

   localparam int DUTY_W   = 8;
   localparam int MOTION_W = 2;
   localparam int BIAS_W   = 9;
   localparam int VALUE_W  = 8;
   localparam int OP_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 9;

   typedef enum logic [OP_W-1:0] {
      OP_SET_SPEED  = 3'd0,
      OP_SET_STRAFE = 3'd1,
      OP_SET_STEER  = 3'd2,
      OP_ESTOP      = 3'd3,
      OP_DRIVE      = 3'd4
   } opcode_type;

   typedef enum logic [MOTION_W-1:0] {
      MOTION_STOP    = 2'd0,
      MOTION_FORWARD = 2'd1,
      MOTION_REVERSE = 2'd2
   } motion_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_FL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_FR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_RL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_RR = 3'd5;

   // stage load strobes of the three-deep pipeline
   typedef struct packed {
      logic ld_mix;
      logic ld_prod;
      logic ld_out;
   } pipe_ctl_type;

endpackage

// File: rtl/core/mecanum_drive_mixer_core.sv
// Mecanum drive mixer core.
// Input channel req_*: one beat carries an opcode and a signed value.
//   Set speed, set strafe and set steer store the value saturated to +/-10;
//   emergency stop clears all three; these beats produce no result.
//   A drive beat mixes the stored commands for the four wheels.
// Result channel rsp_*: one beat per drive beat, in order, carrying a PWM
//   duty and a motion code (stop, forward, reverse) for each wheel.
// Configuration port csr_*: pwm_min, pwm_max and four per-wheel duty biases,
//   written while the core is idle; indexes beyond the last register are ignored.
// Path: an accepted drive beat passes the mix register, the slope product register
//   and the output register in that order; rsp_valid rises once it reaches the last.
// Throughput: one beat per cycle on both channels; the three stages each hold
//   one beat and refill bubbles, so a stalled receiver only holds off req_ready
//   once every stage is full.
// Reset (synchronous): commands cleared, registers back to their defaults,
//   pipeline emptied. Command beats take effect as soon as they are accepted.
// depends on mdm_pkg, mdm_cmd_mixer, mdm_wheel_map and the macros header
`include "mecanum_drive_mixer_core_macros.svh"
module mecanum_drive_mixer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mdm_pkg::OP_W-1:0]             req_opcode,
   input  logic signed [mdm_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mdm_pkg::DUTY_W-1:0]           rsp_duty_front_left,
   output logic [mdm_pkg::DUTY_W-1:0]           rsp_duty_front_right,
   output logic [mdm_pkg::DUTY_W-1:0]           rsp_duty_rear_left,
   output logic [mdm_pkg::DUTY_W-1:0]           rsp_duty_rear_right,
   output logic [mdm_pkg::MOTION_W-1:0]         rsp_motion_front_left,
   output logic [mdm_pkg::MOTION_W-1:0]         rsp_motion_front_right,
   output logic [mdm_pkg::MOTION_W-1:0]         rsp_motion_rear_left,
   output logic [mdm_pkg::MOTION_W-1:0]         rsp_motion_rear_right,
   input  logic                                 csr_wr_en,
   input  logic [mdm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mdm_pkg::CSR_DAT_W-1:0]        csr_wdata
);
   import mdm_pkg::*;

   logic [DUTY_W-1:0]              pwm_min_ff;
   logic [DUTY_W-1:0]              pwm_max_ff;
   logic signed [3:0][BIAS_W-1:0]  bias_ff;
   logic                           v_mix_ff, v_mix_in;
   logic                           v_prod_ff, v_prod_in;
   logic                           v_out_ff, v_out_in;
   logic                           rdy_mix, rdy_prod, rdy_out;
   logic                           beat;
   pipe_ctl_type                   ctl;
   logic signed [3:0][MIX_W-1:0]   mix;
   logic [3:0][DUTY_W-1:0]         duty;
   logic [3:0][MOTION_W-1:0]       motion;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_min_ff <= '0;
         pwm_max_ff <= '1;
         bias_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PWM_MIN: pwm_min_ff <= csr_wdata[DUTY_W-1:0];
            CSR_PWM_MAX: pwm_max_ff <= csr_wdata[DUTY_W-1:0];
            CSR_BIAS_FL: bias_ff[0] <= $signed(csr_wdata[BIAS_W-1:0]);
            CSR_BIAS_FR: bias_ff[1] <= $signed(csr_wdata[BIAS_W-1:0]);
            CSR_BIAS_RL: bias_ff[2] <= $signed(csr_wdata[BIAS_W-1:0]);
            CSR_BIAS_RR: bias_ff[3] <= $signed(csr_wdata[BIAS_W-1:0]);
            default: ;
         endcase
      end
   end

   // pipeline flow control: a stage takes a beat when empty or draining
   always_comb begin
      rdy_out     = !v_out_ff || rsp_ready;
      rdy_prod    = !v_prod_ff || rdy_out;
      rdy_mix     = !v_mix_ff || rdy_prod;
      req_ready   = rdy_mix;
      beat        = req_valid && req_ready;
      ctl.ld_mix  = beat && (req_opcode == OP_DRIVE);
      ctl.ld_prod = v_mix_ff && rdy_prod;
      ctl.ld_out  = v_prod_ff && rdy_out;
      v_mix_in    = ctl.ld_mix || (v_mix_ff && !rdy_prod);
      v_prod_in   = ctl.ld_prod || (v_prod_ff && !rdy_out);
      v_out_in    = ctl.ld_out || (v_out_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_mix_ff  <= 1'b0;
         v_prod_ff <= 1'b0;
         v_out_ff  <= 1'b0;
      end else begin
         v_mix_ff  <= v_mix_in;
         v_prod_ff <= v_prod_in;
         v_out_ff  <= v_out_in;
      end
   end

   mdm_cmd_mixer u_cmd (
      .clock  (clock),
      .reset  (reset),
      .beat   (beat),
      .opcode (req_opcode),
      .value  (req_value),
      .ctl    (ctl),
      .mix    (mix)
   );

   // one duty mapper per wheel: fl, fr, rl, rr
   for (genvar w = 0; w < 4; w++) begin : g_wheel
      mdm_wheel_map u_map (
         .clock   (clock),
         .ctl     (ctl),
         .mix     (mix[w]),
         .pwm_min (pwm_min_ff),
         .pwm_max (pwm_max_ff),
         .bias    (bias_ff[w]),
         .duty    (duty[w]),
         .motion  (motion[w])
      );
   end

   assign rsp_valid              = v_out_ff;
   assign rsp_duty_front_left    = duty[0];
   assign rsp_duty_front_right   = duty[1];
   assign rsp_duty_rear_left     = duty[2];
   assign rsp_duty_rear_right    = duty[3];
   assign rsp_motion_front_left  = motion[0];
   assign rsp_motion_front_right = motion[1];
   assign rsp_motion_rear_left   = motion[2];
   assign rsp_motion_rear_right  = motion[3];

   `MDM_ASSERT(a_mix_held, clock, reset, v_mix_ff && !rdy_prod |=> v_mix_ff)
   `MDM_ASSERT(a_prod_held, clock, reset, v_prod_ff && !rdy_out |=> v_prod_ff)
   `MDM_ASSERT(a_stall_full, clock, reset,
      !req_ready |-> v_mix_ff && v_prod_ff && v_out_ff)
   `MDM_ASSERT(a_stop_zero_duty, clock, reset,
      rsp_valid && rsp_motion_front_left == MOTION_STOP |-> rsp_duty_front_left == 0)
   `MDM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)

endmodule

// File: rtl/core/mdm_cmd_mixer.sv
// command registers and the wheel mix stage of the mecanum mixer
// depends on mdm_pkg and mecanum_drive_mixer_core_macros.svh
`include "mecanum_drive_mixer_core_macros.svh"
module mdm_cmd_mixer (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    beat,
   input  logic [mdm_pkg::OP_W-1:0]                opcode,
   input  logic signed [mdm_pkg::VALUE_W-1:0]      value,
   input  mdm_pkg::pipe_ctl_type                   ctl,
   output logic signed [3:0][mdm_pkg::MIX_W-1:0]   mix
);
   import mdm_pkg::*;

   localparam logic signed [VALUE_W-1:0] VAL_HI = VALUE_W'(CMD_LIMIT);
   localparam logic signed [VALUE_W-1:0] VAL_LO = -VALUE_W'(CMD_LIMIT);
   localparam logic signed [MIX_W-1:0]   MIX_HI = MIX_W'(CMD_LIMIT);
   localparam logic signed [MIX_W-1:0]   MIX_LO = -MIX_W'(CMD_LIMIT);
   localparam logic signed [CMD_W-1:0]   CMD_HI = CMD_W'(CMD_LIMIT);
   localparam logic signed [CMD_W-1:0]   CMD_LO = -CMD_W'(CMD_LIMIT);

   logic signed [CMD_W-1:0] speed_ff, speed_in;
   logic signed [CMD_W-1:0] strafe_ff, strafe_in;
   logic signed [CMD_W-1:0] steer_ff, steer_in;
   logic signed [CMD_W-1:0] sat_val;
   logic signed [3:0][MIX_W-1:0] mix_ff, mix_in;
   logic signed [MIX_W-1:0] sp, st, sr;

   // skid steering: clamp to the half range that matches the speed sign
   function automatic logic signed [MIX_W-1:0] skid(input logic signed [MIX_W-1:0] s,
                                                     input logic signed [MIX_W-1:0] d);
      logic signed [MIX_W-1:0] sum;
      sum = s + d;
      if (s > 0) begin
         skid = (sum < 0) ? '0 : ((sum > MIX_HI) ? MIX_HI : sum);
      end else begin
         skid = (sum < MIX_LO) ? MIX_LO : ((sum > 0) ? '0 : sum);
      end
   endfunction

   // saturate the command value
   always_comb begin
      if (value > VAL_HI) begin
         sat_val = CMD_HI;
      end else if (value < VAL_LO) begin
         sat_val = CMD_LO;
      end else begin
         sat_val = CMD_W'(value);
      end
   end

   // command updates
   always_comb begin
      speed_in  = speed_ff;
      strafe_in = strafe_ff;
      steer_in  = steer_ff;
      if (beat) begin
         case (opcode_type'(opcode))
            OP_SET_SPEED: begin
               if (sat_val != speed_ff) begin
                  speed_in = sat_val;
                  if (sat_val == 0) steer_in = '0;
               end
            end
            OP_SET_STRAFE: strafe_in = sat_val;
            OP_SET_STEER:  steer_in  = sat_val;
            OP_ESTOP: begin
               speed_in  = '0;
               strafe_in = '0;
               steer_in  = '0;
            end
            default: ;
         endcase
      end
   end

   // mix the stored commands into four wheel values (fl, fr, rl, rr)
   always_comb begin
      sp = MIX_W'(speed_ff);
      st = MIX_W'(strafe_ff);
      sr = MIX_W'(steer_ff);
      mix_in = {sp, sp, sp, sp};
      if (strafe_ff != 0) begin
         mix_in[0] = sp + st;
         mix_in[1] = sp - st;
         mix_in[2] = sp - st;
         mix_in[3] = sp + st;
      end else if (steer_ff != 0) begin
         if (speed_ff == 0) begin
            mix_in[0] = sr;
            mix_in[1] = -sr;
            mix_in[2] = sr;
            mix_in[3] = -sr;
         end else begin
            mix_in[0] = skid(sp, sr);
            mix_in[1] = skid(sp, -sr);
            mix_in[2] = skid(sp, sr);
            mix_in[3] = skid(sp, -sr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= '0;
         strafe_ff <= '0;
         steer_ff  <= '0;
      end else begin
         speed_ff  <= speed_in;
         strafe_ff <= strafe_in;
         steer_ff  <= steer_in;
      end
   end

   // mix register, loaded by drive beats
   always_ff @(posedge clock) begin
      if (ctl.ld_mix) begin
         mix_ff <= mix_in;
      end
   end

   assign mix = mix_ff;

   `MDM_ASSERT(a_cmd_range, clock, reset,
      speed_ff <= CMD_HI && speed_ff >= CMD_LO && strafe_ff <= CMD_HI &&
      strafe_ff >= CMD_LO && steer_ff <= CMD_HI && steer_ff >= CMD_LO)
   `MDM_ASSERT(a_estop_clears, clock, reset,
      beat && opcode == OP_ESTOP |=> speed_ff == 0 && strafe_ff == 0 && steer_ff == 0)
   `MDM_ASSERT(a_speed_zero_clears_steer, clock, reset,
      beat && opcode == OP_SET_SPEED && sat_val == 0 && speed_ff != 0 |=> steer_ff == 0)
   `MDM_ASSERT(a_drive_keeps_cmds, clock, reset,
      beat && opcode == OP_DRIVE |=> $stable(speed_ff) && $stable(steer_ff))

endmodule

// File: rtl/core/mdm_wheel_map.sv
// per-wheel duty mapping: magnitude times slope, divide by the limit, offset, clamp
// depends on mdm_pkg
module mdm_wheel_map (
   input  logic                                 clock,
   input  mdm_pkg::pipe_ctl_type                ctl,
   input  logic signed [mdm_pkg::MIX_W-1:0]     mix,
   input  logic [mdm_pkg::DUTY_W-1:0]           pwm_min,
   input  logic [mdm_pkg::DUTY_W-1:0]           pwm_max,
   input  logic signed [mdm_pkg::BIAS_W-1:0]    bias,
   output logic [mdm_pkg::DUTY_W-1:0]           duty,
   output logic [mdm_pkg::MOTION_W-1:0]         motion
);
   import mdm_pkg::*;

   localparam int ABS_W = PROD_W - 1;
   localparam int SUM_W = DUTY_W + 3;
   localparam logic [MIX_W-1:0] LIM_U = MIX_W'(CMD_LIMIT);

   logic [MIX_W-1:0]               abs_mix;
   logic [MAG_W-1:0]               mag;
   logic signed [DIFF_W-1:0]       diff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic                           zero_ff;
   logic                           fwd_ff;
   logic [ABS_W-1:0]               abs_prod;
   logic [ABS_W+RECIP_W-1:0]       recip_prod;
   logic [DUTY_W-1:0]              quot;
   logic signed [SUM_W-1:0]        squot;
   logic signed [SUM_W-1:0]        sum;
   logic [DUTY_W-1:0]              duty_ff, duty_in;
   logic [MOTION_W-1:0]            motion_ff, motion_in;

   // stage one: magnitude and slope product
   always_comb begin
      abs_mix = mix[MIX_W-1] ? MIX_W'(-mix) : MIX_W'(mix);
      mag     = (abs_mix > LIM_U) ? MAG_W'(CMD_LIMIT) : abs_mix[MAG_W-1:0];
      diff    = $signed({1'b0, pwm_max}) - $signed({1'b0, pwm_min});
      prod_in = $signed({1'b0, mag}) * diff;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_prod) begin
         prod_ff <= prod_in;
         zero_ff <= (mix == 0);
         fwd_ff  <= (mix > 0);
      end
   end

   // stage two: truncating divide, offset and clamp
   always_comb begin
      abs_prod   = prod_ff[PROD_W-1] ? ABS_W'(-prod_ff) : ABS_W'(prod_ff);
      recip_prod = (ABS_W + RECIP_W)'(abs_prod) * (ABS_W + RECIP_W)'(RECIP);
      quot       = recip_prod[RECIP_SHIFT +: DUTY_W];
      squot      = prod_ff[PROD_W-1] ? -$signed(SUM_W'({1'b0, quot}))
                                     : $signed(SUM_W'({1'b0, quot}));
      sum        = squot + $signed(SUM_W'({1'b0, pwm_min})) + SUM_W'(bias);
      if (zero_ff) begin
         duty_in   = '0;
         motion_in = MOTION_STOP;
      end else begin
         if (sum < 0) begin
            duty_in = '0;
         end else if (sum > $signed(SUM_W'({1'b0, pwm_max}))) begin
            duty_in = pwm_max;
         end else begin
            duty_in = sum[DUTY_W-1:0];
         end
         motion_in = fwd_ff ? MOTION_FORWARD : MOTION_REVERSE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_out) begin
         duty_ff   <= duty_in;
         motion_ff <= motion_in;
      end
   end

   assign duty   = duty_ff;
   assign motion = motion_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// testbench for mecanum_drive_mixer_core: directed and random command traffic,
// each drive result checked against a behavioral wheel mixer kept in this file
// depends on mdm_pkg and the mecanum_drive_mixer_core rtl
module testbench;
   import mdm_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 215;
   localparam int NUM_WHEELS    = 4;
   localparam int NUM_REGS      = 6;
   localparam int MAX_GAP       = 5;

   localparam logic [OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0]      OP_SPARE_LAST  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 8'sh7f;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 8'sh80;

   typedef enum int {
      CFG_DEFAULT,
      CFG_RANDOM,
      CFG_INVERTED,
      CFG_EXTREME,
      CFG_NARROW
   } cfg_kind_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0][DUTY_W-1:0]   duty;
      logic [NUM_WHEELS-1:0][MOTION_W-1:0] motion;
   } wheel_set_type;

   typedef logic [NUM_REGS-1:0][CSR_DAT_W-1:0] reg_image_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_valid  = 1'b0;
   logic                        req_ready;
   logic [OP_W-1:0]             req_opcode = '0;
   logic signed [VALUE_W-1:0]   req_value  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready  = 1'b0;
   logic [DUTY_W-1:0]           rsp_duty_front_left;
   logic [DUTY_W-1:0]           rsp_duty_front_right;
   logic [DUTY_W-1:0]           rsp_duty_rear_left;
   logic [DUTY_W-1:0]           rsp_duty_rear_right;
   logic [MOTION_W-1:0]         rsp_motion_front_left;
   logic [MOTION_W-1:0]         rsp_motion_front_right;
   logic [MOTION_W-1:0]         rsp_motion_rear_left;
   logic [MOTION_W-1:0]         rsp_motion_rear_right;
   logic                        csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index  = '0;
   logic [CSR_DAT_W-1:0]        csr_wdata  = '0;

   // behavioral copy of the command latch and the duty registers
   int speed_cmd   = 0;
   int strafe_cmd  = 0;
   int steer_cmd   = 0;
   int pwm_min_cfg = 0;
   int pwm_max_cfg = 255;
   int bias_cfg [NUM_WHEELS] = '{default: 0};

   wheel_set_type expected_wheels [$];
   int            errors      = 0;
   int            cycle_count = 0;
   bit            idling_on   = 1'b1;
   string         wheel_name [NUM_WHEELS] =
      '{"front_left", "front_right", "rear_left", "rear_right"};

   mecanum_drive_mixer_core uut (.*);

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int clamp_to(int x, int lo, int hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   // skid steering keeps the wheel on the side of the speed sign
   function automatic int skid_mix(int s, int delta);
      if (s > 0) return clamp_to(s + delta, 0, CMD_LIMIT);
      return clamp_to(s + delta, -CMD_LIMIT, 0);
   endfunction

   // apply one command beat; returns 1 with the wheel set for a drive beat
   function automatic bit mix_command(input logic [OP_W-1:0] op,
         input logic signed [VALUE_W-1:0] val, output wheel_set_type wheels);
      int v;
      int mag;
      int d;
      int mix [NUM_WHEELS];
      v = clamp_to(int'(val), -CMD_LIMIT, CMD_LIMIT);
      wheels = '0;
      case (op)
         OP_SET_SPEED: begin
            // steer drops only on a real change to zero speed
            if (v != speed_cmd) begin
               speed_cmd = v;
               if (v == 0) steer_cmd = 0;
            end
            return 1'b0;
         end
         OP_SET_STRAFE: begin
            strafe_cmd = v;
            return 1'b0;
         end
         OP_SET_STEER: begin
            steer_cmd = v;
            return 1'b0;
         end
         OP_ESTOP: begin
            speed_cmd  = 0;
            strafe_cmd = 0;
            steer_cmd  = 0;
            return 1'b0;
         end
         OP_DRIVE: ;
         default: return 1'b0;
      endcase

      for (int w = 0; w < NUM_WHEELS; w++) mix[w] = speed_cmd;
      if (strafe_cmd != 0) begin
         mix[0] += strafe_cmd;
         mix[1] -= strafe_cmd;
         mix[2] -= strafe_cmd;
         mix[3] += strafe_cmd;
      end else if (steer_cmd != 0) begin
         if (speed_cmd == 0) begin
            // spin in place
            mix[0] = steer_cmd;
            mix[1] = -steer_cmd;
            mix[2] = steer_cmd;
            mix[3] = -steer_cmd;
         end else begin
            mix[0] = skid_mix(speed_cmd, steer_cmd);
            mix[1] = skid_mix(speed_cmd, -steer_cmd);
            mix[2] = skid_mix(speed_cmd, steer_cmd);
            mix[3] = skid_mix(speed_cmd, -steer_cmd);
         end
      end

      // magnitude to duty, bias, clamp to 0..max
      for (int w = 0; w < NUM_WHEELS; w++) begin
         mag = clamp_to(mix[w] < 0 ? -mix[w] : mix[w], 0, CMD_LIMIT);
         if (mag == 0) begin
            wheels.duty[w]   = '0;
            wheels.motion[w] = MOTION_STOP;
         end else begin
            d = mag * (pwm_max_cfg - pwm_min_cfg) / CMD_LIMIT + pwm_min_cfg + bias_cfg[w];
            if (d < 0) d = 0;
            if (d > pwm_max_cfg) d = pwm_max_cfg;
            wheels.duty[w]   = DUTY_W'(d);
            wheels.motion[w] = (mix[w] > 0) ? MOTION_FORWARD : MOTION_REVERSE;
         end
      end
      return 1'b1;
   endfunction

   // send one command beat; valid stays up until accepted
   task automatic send_beat(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val);
      int gap;
      wheel_set_type wheels;
      gap = idling_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mix_command(op, val, wheels)) expected_wheels.push_back(wheels);
   endtask

   // hold off the sender until every result is back and the pipe has settled
   task automatic wait_for_idle;
      req_valid <= 1'b0;
      while (expected_wheels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all six registers, then one random index beyond the last that must be ignored
   task automatic load_config(input reg_image_type regs);
      for (int i = CSR_PWM_MIN; i <= CSR_BIAS_RR; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= regs[i];
         @(posedge clock);
         case (CSR_IDX_W'(i))
            CSR_PWM_MIN: pwm_min_cfg = int'(regs[i][DUTY_W-1:0]);
            CSR_PWM_MAX: pwm_max_cfg = int'(regs[i][DUTY_W-1:0]);
            default:     bias_cfg[i - CSR_BIAS_FL] = int'($signed(regs[i]));
         endcase
      end
      csr_index <= CSR_IDX_W'($urandom_range(int'(CSR_BIAS_RR) + 1, int'(CSR_SPARE_LAST)));
      csr_wdata <= CSR_DAT_W'($urandom());
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pick_config(input cfg_kind_type kind);
      reg_image_type regs;
      int lo;
      int hi;
      case (kind)
         CFG_DEFAULT: begin
            lo = 0;
            hi = 255;
            for (int w = 0; w < NUM_WHEELS; w++) regs[CSR_BIAS_FL + w] = '0;
         end
         CFG_RANDOM: begin
            lo = $urandom_range(0, 255);
            hi = $urandom_range(0, 255);
            for (int w = 0; w < NUM_WHEELS; w++)
               regs[CSR_BIAS_FL + w] = CSR_DAT_W'($urandom());
         end
         CFG_INVERTED: begin
            // min above max gives a falling slope
            lo = $urandom_range(128, 255);
            hi = $urandom_range(0, 127);
            for (int w = 0; w < NUM_WHEELS; w++)
               regs[CSR_BIAS_FL + w] = CSR_DAT_W'(int'($urandom_range(0, 80)) - 40);
         end
         CFG_EXTREME: begin
            lo = ($urandom_range(0, 1) != 0) ? 255 : 0;
            hi = ($urandom_range(0, 1) != 0) ? 255 : 0;
            for (int w = 0; w < NUM_WHEELS; w++)
               case ($urandom_range(0, 3))
                  0:       regs[CSR_BIAS_FL + w] = 9'h100;
                  1:       regs[CSR_BIAS_FL + w] = 9'h0ff;
                  2:       regs[CSR_BIAS_FL + w] = 9'h101;
                  default: regs[CSR_BIAS_FL + w] = '0;
               endcase
         end
         default: begin
            lo = $urandom_range(20, 60);
            hi = $urandom_range(180, 240);
            for (int w = 0; w < NUM_WHEELS; w++)
               regs[CSR_BIAS_FL + w] = CSR_DAT_W'(int'($urandom_range(0, 40)) - 20);
         end
      endcase
      // bit 8 of the duty registers is beyond their width
      regs[CSR_PWM_MIN] = {1'($urandom_range(0, 1)), DUTY_W'(lo)};
      regs[CSR_PWM_MAX] = {1'($urandom_range(0, 1)), DUTY_W'(hi)};
      load_config(regs);
   endtask

   function automatic logic signed [VALUE_W-1:0] draw_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return VALUE_W'(int'($urandom_range(0, 2 * CMD_LIMIT + 4)) - CMD_LIMIT - 2);
      if (pick == 7) return '0;
      return VALUE_W'($urandom());
   endfunction

   task automatic send_random_beat;
      int pick;
      logic [OP_W-1:0] op;
      logic signed [VALUE_W-1:0] val;
      pick = $urandom_range(0, 99);
      val  = draw_value();
      if (pick < 34) op = OP_DRIVE;
      else if (pick < 52) op = OP_SET_SPEED;
      else if (pick < 68) begin
         op = OP_SET_STRAFE;
         // zero strafe half the time so the steer paths stay reachable
         if (pick < 60) val = '0;
      end
      else if (pick < 86) op = OP_SET_STEER;
      else if (pick < 94) op = OP_ESTOP;
      else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      send_beat(op, val);
   endtask

   // compare one accepted result beat with the oldest expectation
   task automatic check_wheels;
      wheel_set_type want;
      wheel_set_type got;
      got.duty[0]   = rsp_duty_front_left;
      got.duty[1]   = rsp_duty_front_right;
      got.duty[2]   = rsp_duty_rear_left;
      got.duty[3]   = rsp_duty_rear_right;
      got.motion[0] = rsp_motion_front_left;
      got.motion[1] = rsp_motion_front_right;
      got.motion[2] = rsp_motion_rear_left;
      got.motion[3] = rsp_motion_rear_right;
      if (expected_wheels.size() == 0) begin
         $display("%0t: result beat with nothing expected, actual %h", $time, got);
         errors++;
      end else begin
         want = expected_wheels.pop_front();
         for (int w = 0; w < NUM_WHEELS; w++) begin
            if (got.duty[w] !== want.duty[w]) begin
               $display("%0t: duty_%s expected %0d actual %0d", $time, wheel_name[w],
                        want.duty[w], got.duty[w]);
               errors++;
            end
            if (got.motion[w] !== want.motion[w]) begin
               $display("%0t: motion_%s expected %0d actual %0d", $time, wheel_name[w],
                        want.motion[w], got.motion[w]);
               errors++;
            end
         end
      end
   endtask

   // result side: random stall per beat, check at each accepted beat
   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idling_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_wheels();
      end
   end

   // all commands clear after reset: every wheel stopped
   task automatic test_power_on_drive;
      send_beat(OP_DRIVE, VALUE_MAX);
      wait_for_idle();
   endtask

   task automatic test_command_saturation;
      send_beat(OP_SET_SPEED, VALUE_MAX);
      send_beat(OP_DRIVE, '0);
      send_beat(OP_SET_SPEED, VALUE_MIN);
      send_beat(OP_DRIVE, VALUE_MIN);
      wait_for_idle();
   endtask

   task automatic test_mix_modes;
      // strafe on top of speed
      send_beat(OP_SET_STRAFE, -8'sd3);
      send_beat(OP_SET_SPEED, 8'sd5);
      send_beat(OP_DRIVE, '0);
      // skid steering, forward then reverse
      send_beat(OP_SET_STRAFE, '0);
      send_beat(OP_SET_STEER, 8'sd8);
      send_beat(OP_DRIVE, '0);
      send_beat(OP_SET_SPEED, -8'sd6);
      send_beat(OP_DRIVE, '0);
      // speed change to zero clears steer
      send_beat(OP_SET_SPEED, '0);
      send_beat(OP_DRIVE, '0);
      // spin in place; zero speed again keeps steer
      send_beat(OP_SET_STEER, -8'sd7);
      send_beat(OP_DRIVE, '0);
      send_beat(OP_SET_SPEED, '0);
      send_beat(OP_DRIVE, '0);
      // emergency stop clears everything
      send_beat(OP_ESTOP, VALUE_MAX);
      send_beat(OP_DRIVE, '0);
      wait_for_idle();
   endtask

   // unused opcodes change nothing and return nothing
   task automatic test_spare_opcodes;
      send_beat(OP_SET_STEER, 8'sd4);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send_beat(OP_W'(op), op[0] ? VALUE_MAX : VALUE_MIN);
      send_beat(OP_DRIVE, '0);
      wait_for_idle();
   endtask

   task automatic test_config_extremes;
      reg_image_type regs;
      // min above max, bias at both ends and one step above the negative end
      regs[CSR_PWM_MIN] = 9'd200;
      regs[CSR_PWM_MAX] = 9'd40;
      regs[CSR_BIAS_FL] = 9'h100;
      regs[CSR_BIAS_FR] = 9'h0ff;
      regs[CSR_BIAS_RL] = 9'h101;
      regs[CSR_BIAS_RR] = '0;
      load_config(regs);
      send_beat(OP_SET_STRAFE, -8'sd5);
      send_beat(OP_SET_SPEED, 8'sd3);
      send_beat(OP_DRIVE, '0);
      wait_for_idle();
      // flat mapping at full scale
      regs[CSR_PWM_MIN] = 9'h1ff;
      regs[CSR_PWM_MAX] = 9'h1ff;
      regs[CSR_BIAS_FL] = 9'h0ff;
      regs[CSR_BIAS_FR] = 9'h100;
      regs[CSR_BIAS_RL] = '0;
      regs[CSR_BIAS_RR] = 9'h101;
      load_config(regs);
      send_beat(OP_DRIVE, '0);
      wait_for_idle();
   endtask

   // random phases, each under its own register setting and idling mode
   task automatic test_random_traffic;
      cfg_kind_type kind;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         kind = (phase <= CFG_NARROW) ? cfg_kind_type'(phase)
                                      : cfg_kind_type'($urandom_range(CFG_DEFAULT, CFG_NARROW));
         pick_config(kind);
         if (phase == 0) idling_on = 1'b1;
         else if (phase == 1) idling_on = 1'b0;
         else idling_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_beat();
         wait_for_idle();
      end
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_power_on_drive();
      test_command_saturation();
      test_mix_modes();
      test_spare_opcodes();
      test_config_extremes();
      test_random_traffic();
      wait_for_idle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mdm_pkg.sv
rtl/core/mdm_cmd_mixer.sv
rtl/core/mdm_wheel_map.sv
rtl/core/mecanum_drive_mixer_core.sv
sim/testbench.sv
